>>> rtl/core/tfn_pkg.sv
// Shared types, widths and helpers for the triangle face normal pipeline.
package tfn_pkg;

    localparam int COORD_W   = 24;
    localparam int ADDR_W    = 10;
    localparam int VERTEX_DEPTH = 1 << ADDR_W;
    localparam int STORE_W   = 3 * COORD_W;
    localparam int EDGE_W    = COORD_W + 1;
    localparam int MAG_W     = COORD_W + 1;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int LEN_W     = 2 * MAG_W;
    localparam int ROOT_W    = MAG_W;
    localparam int REM_W     = ROOT_W + 1;
    localparam int Q_W       = 15;
    localparam int NUM_W     = MAG_W + Q_W;
    localparam int DEN_W     = ROOT_W + 1;
    localparam int NORM_W    = 16;
    localparam int PROD_W    = 2 * NORM_W;
    localparam int DIFF_W    = PROD_W + 1;
    localparam int UNIT_ONE  = 16384;
    localparam int ROUND_SH  = 14;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TRI   = 1'b1;

    typedef struct packed {
        logic                      op;
        logic [ADDR_W-1:0]         vertex_slot;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic [ADDR_W-1:0]         index_a;
        logic [ADDR_W-1:0]         index_b;
        logic [ADDR_W-1:0]         index_c;
    } cmd_t;

    typedef struct packed {
        logic signed [NORM_W-1:0] normal_x;
        logic signed [NORM_W-1:0] normal_y;
        logic signed [NORM_W-1:0] normal_z;
        logic                     degenerate;
    } result_t;

    typedef struct packed {
        logic valid;
        logic zero;
    } unit_stat_t;

    // Round a Q2.28 difference half away from zero to Q1.14 and clamp.
    function automatic logic [NORM_W-1:0] round_norm(input logic signed [DIFF_W-1:0] v);
        logic             neg;
        logic [DIFF_W-1:0] mag;
        logic [DIFF_W-1:0] r;
        neg = v[DIFF_W-1];
        mag = neg ? DIFF_W'(-v) : DIFF_W'(v);
        r   = (mag + DIFF_W'(1 << (ROUND_SH - 1))) >> ROUND_SH;
        if (r > DIFF_W'(UNIT_ONE))
        begin
            r = DIFF_W'(UNIT_ONE);
        end
        return neg ? NORM_W'(-r) : NORM_W'(r);
    endfunction

endpackage

>>> rtl/core/triangle_face_normal_top.sv
// Top level of the triangle face normal pipeline: vertex store, edges, normalize, cross.
//
//  channel   signals              direction  transfer when
//  command   start, busy, cmd     in         start && !busy at rising clk
//  result    done, result         out        done high for one cycle
//
// One command enters every cycle; busy stays low because nothing stalls.
// A triangle result passes the store read, the edge stages, the square root steps,
// 16 divider stages and two cross stages.
// Vertex writes give no result and take effect for the very next command.
// rst_n clears every valid bit at once; store contents are undefined until written.
// The receiver cannot hold results off, so each result stands for exactly one cycle.
module triangle_face_normal_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  tfn_pkg::cmd_t    cmd,
    output logic             done,
    output tfn_pkg::result_t result
);

    localparam int COORD_W = tfn_pkg::COORD_W;
    localparam int STORE_W = tfn_pkg::STORE_W;
    localparam int EDGE_W  = tfn_pkg::EDGE_W;
    localparam int MAG_W   = tfn_pkg::MAG_W;
    localparam int SQ_W    = tfn_pkg::SQ_W;
    localparam int LEN_W   = tfn_pkg::LEN_W;
    localparam int NORM_W  = tfn_pkg::NORM_W;
    localparam int PROD_W  = tfn_pkg::PROD_W;
    localparam int DIFF_W  = tfn_pkg::DIFF_W;

    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Three copies of the store, one read port each, written together.
    logic [STORE_W-1:0] mem_a [tfn_pkg::VERTEX_DEPTH];
    logic [STORE_W-1:0] mem_b [tfn_pkg::VERTEX_DEPTH];
    logic [STORE_W-1:0] mem_c [tfn_pkg::VERTEX_DEPTH];

    logic [STORE_W-1:0] rd_a_reg, rd_b_reg, rd_c_reg;
    logic               v1_reg;

    always_ff @(posedge clk)
    begin
        if (accept && cmd.op == tfn_pkg::OP_WRITE)
        begin
            mem_a[cmd.vertex_slot] <= {cmd.coord_x, cmd.coord_y, cmd.coord_z};
            mem_b[cmd.vertex_slot] <= {cmd.coord_x, cmd.coord_y, cmd.coord_z};
            mem_c[cmd.vertex_slot] <= {cmd.coord_x, cmd.coord_y, cmd.coord_z};
        end
    end

    always_ff @(posedge clk)
    begin
        rd_a_reg <= mem_a[cmd.index_a];
        rd_b_reg <= mem_b[cmd.index_b];
        rd_c_reg <= mem_c[cmd.index_c];
    end

    // Stage 1: edges e0 = A - B, e1 = B - C as sign and magnitude.
    logic [2:0][MAG_W-1:0] mag0_next, mag1_next;
    logic [2:0]            neg0_next, neg1_next;

    always_comb
    begin
        logic signed [EDGE_W-1:0] d0;
        logic signed [EDGE_W-1:0] d1;
        logic signed [COORD_W-1:0] ca, cb, cc;
        for (int i = 0; i < 3; i++)
        begin
            // component i: x at the top of the stored word
            ca = $signed(rd_a_reg[STORE_W-1-i*COORD_W -: COORD_W]);
            cb = $signed(rd_b_reg[STORE_W-1-i*COORD_W -: COORD_W]);
            cc = $signed(rd_c_reg[STORE_W-1-i*COORD_W -: COORD_W]);
            d0 = EDGE_W'(ca) - EDGE_W'(cb);
            d1 = EDGE_W'(cb) - EDGE_W'(cc);
            neg0_next[i] = d0[EDGE_W-1];
            neg1_next[i] = d1[EDGE_W-1];
            mag0_next[i] = d0[EDGE_W-1] ? MAG_W'(-d0) : MAG_W'(d0);
            mag1_next[i] = d1[EDGE_W-1] ? MAG_W'(-d1) : MAG_W'(d1);
        end
    end

    logic [2:0][MAG_W-1:0] mag0_s1_reg, mag1_s1_reg, mag0_s2_reg, mag1_s2_reg;
    logic [2:0][MAG_W-1:0] mag0_s3_reg, mag1_s3_reg;
    logic [2:0]            neg0_s1_reg, neg1_s1_reg, neg0_s2_reg, neg1_s2_reg;
    logic [2:0]            neg0_s3_reg, neg1_s3_reg;
    logic [2:0][SQ_W-1:0]  sq0_reg, sq1_reg;
    logic [LEN_W-1:0]      len0_reg, len1_reg;
    logic                  v2_reg, v3_reg, v4_reg;

    always_ff @(posedge clk)
    begin
        mag0_s1_reg <= mag0_next;
        mag1_s1_reg <= mag1_next;
        neg0_s1_reg <= neg0_next;
        neg1_s1_reg <= neg1_next;
        // Stage 2: square each magnitude.
        for (int i = 0; i < 3; i++)
        begin
            sq0_reg[i] <= SQ_W'(mag0_s1_reg[i]) * SQ_W'(mag0_s1_reg[i]);
            sq1_reg[i] <= SQ_W'(mag1_s1_reg[i]) * SQ_W'(mag1_s1_reg[i]);
        end
        mag0_s2_reg <= mag0_s1_reg;
        mag1_s2_reg <= mag1_s1_reg;
        neg0_s2_reg <= neg0_s1_reg;
        neg1_s2_reg <= neg1_s1_reg;
        // Stage 3: squared length of each edge.
        len0_reg    <= sq0_reg[0] + sq0_reg[1] + sq0_reg[2];
        len1_reg    <= sq1_reg[0] + sq1_reg[1] + sq1_reg[2];
        mag0_s3_reg <= mag0_s2_reg;
        mag1_s3_reg <= mag1_s2_reg;
        neg0_s3_reg <= neg0_s2_reg;
        neg1_s3_reg <= neg1_s2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept && cmd.op == tfn_pkg::OP_TRI;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Normalize both edges in parallel; both units have identical latency.
    tfn_pkg::unit_stat_t    stat0, stat1;
    logic [2:0][NORM_W-1:0] u0, u1;

    tfn_unit u_unit0 (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v4_reg),
        .mag      (mag0_s3_reg),
        .neg      (neg0_s3_reg),
        .len2     (len0_reg),
        .stat     (stat0),
        .unit_vec (u0)
    );

    tfn_unit u_unit1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v4_reg),
        .mag      (mag1_s3_reg),
        .neg      (neg1_s3_reg),
        .len2     (len1_reg),
        .stat     (stat1),
        .unit_vec (u1)
    );

    // Cross stage 1: the six partial products.
    logic signed [PROD_W-1:0] prod_reg [6];
    logic                     deg_reg;
    logic                     v5_reg;

    always_ff @(posedge clk)
    begin
        prod_reg[0] <= $signed(u0[1]) * $signed(u1[2]);
        prod_reg[1] <= $signed(u0[2]) * $signed(u1[1]);
        prod_reg[2] <= $signed(u0[2]) * $signed(u1[0]);
        prod_reg[3] <= $signed(u0[0]) * $signed(u1[2]);
        prod_reg[4] <= $signed(u0[0]) * $signed(u1[1]);
        prod_reg[5] <= $signed(u0[1]) * $signed(u1[0]);
        deg_reg     <= stat0.zero || stat1.zero;
    end

    // Cross stage 2: subtract, round, clamp; zero the normal on a degenerate face.
    tfn_pkg::result_t result_next;
    tfn_pkg::result_t result_reg;
    logic             done_reg;

    always_comb
    begin
        result_next.degenerate = deg_reg;
        if (deg_reg)
        begin
            result_next.normal_x = '0;
            result_next.normal_y = '0;
            result_next.normal_z = '0;
        end
        else
        begin
            result_next.normal_x = tfn_pkg::round_norm(DIFF_W'(prod_reg[0]) - DIFF_W'(prod_reg[1]));
            result_next.normal_y = tfn_pkg::round_norm(DIFF_W'(prod_reg[2]) - DIFF_W'(prod_reg[3]));
            result_next.normal_z = tfn_pkg::round_norm(DIFF_W'(prod_reg[4]) - DIFF_W'(prod_reg[5]));
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v5_reg   <= stat0.valid;
            done_reg <= v5_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.degenerate |->
            result.normal_x == '0 && result.normal_y == '0 && result.normal_z == '0)
        else $error("degenerate result with nonzero normal");

    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.normal_x <= 16'sd16384 && result.normal_x >= -16'sd16384
              && result.normal_y <= 16'sd16384 && result.normal_y >= -16'sd16384
              && result.normal_z <= 16'sd16384 && result.normal_z >= -16'sd16384)
        else $error("normal component out of range");

    a_done_follows_unit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(stat0.valid, 2) && $past(stat1.valid, 2))
        else $error("result without a normalized edge pair");

endmodule

>>> rtl/core/tfn_unit.sv
// Edge normalizer: pipelined square root followed by pipelined restoring division.
module tfn_unit (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic [2:0][tfn_pkg::MAG_W-1:0]          mag,
    input  logic [2:0]                              neg,
    input  logic [tfn_pkg::LEN_W-1:0]               len2,
    output tfn_pkg::unit_stat_t                     stat,
    output logic [2:0][tfn_pkg::NORM_W-1:0]         unit_vec
);

    localparam int SQ_STEPS = tfn_pkg::ROOT_W;
    localparam int DV_STEPS = tfn_pkg::Q_W;
    localparam int LEN_W    = tfn_pkg::LEN_W;
    localparam int REM_W    = tfn_pkg::REM_W;
    localparam int ROOT_W   = tfn_pkg::ROOT_W;
    localparam int NUM_W    = tfn_pkg::NUM_W;
    localparam int DEN_W    = tfn_pkg::DEN_W;
    localparam int Q_W      = tfn_pkg::Q_W;
    localparam int MAG_W    = tfn_pkg::MAG_W;
    localparam int NORM_W   = tfn_pkg::NORM_W;

    // square root stages
    logic                    sq_v    [0:SQ_STEPS];
    logic                    sq_z    [0:SQ_STEPS];
    logic [LEN_W-1:0]        sq_n    [0:SQ_STEPS];
    logic [REM_W-1:0]        sq_rem  [0:SQ_STEPS];
    logic [ROOT_W-1:0]       sq_root [0:SQ_STEPS];
    logic [2:0][MAG_W-1:0]   sq_mag  [0:SQ_STEPS];
    logic [2:0]              sq_neg  [0:SQ_STEPS];

    always_comb
    begin
        sq_v[0]    = in_valid;
        sq_z[0]    = (len2 == '0);
        sq_n[0]    = len2;
        sq_rem[0]  = '0;
        sq_root[0] = '0;
        sq_mag[0]  = mag;
        sq_neg[0]  = neg;
    end

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sq
        logic [REM_W+1:0] shifted;
        logic [REM_W+1:0] trial;
        logic             take;

        assign shifted = {sq_rem[k], sq_n[k][LEN_W-1-2*k -: 2]};
        assign trial   = {1'b0, sq_root[k], 2'b01};
        assign take    = (shifted >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v[k+1] <= 1'b0;
            end
            else
            begin
                sq_v[k+1] <= sq_v[k];
            end
        end

        always_ff @(posedge clk)
        begin
            sq_rem[k+1]  <= take ? REM_W'(shifted - trial) : REM_W'(shifted);
            sq_root[k+1] <= {sq_root[k][ROOT_W-2:0], take};
            sq_n[k+1]    <= sq_n[k];
            sq_z[k+1]    <= sq_z[k];
            sq_mag[k+1]  <= sq_mag[k];
            sq_neg[k+1]  <= sq_neg[k];
        end
    end

    // division stages: q = (mag * 2^15 + s) / (2 s)
    logic                    dv_v   [0:DV_STEPS];
    logic                    dv_z   [0:DV_STEPS];
    logic [DEN_W-1:0]        dv_d   [0:DV_STEPS];
    logic [2:0][NUM_W-1:0]   dv_rem [0:DV_STEPS];
    logic [2:0][Q_W-1:0]     dv_q   [0:DV_STEPS];
    logic [2:0]              dv_neg [0:DV_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v[0] <= 1'b0;
        end
        else
        begin
            dv_v[0] <= sq_v[SQ_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            dv_rem[0][c] <= (NUM_W'(sq_mag[SQ_STEPS][c]) << Q_W)
                          + NUM_W'(sq_root[SQ_STEPS]);
        end
        dv_q[0]   <= '0;
        dv_d[0]   <= {sq_root[SQ_STEPS], 1'b0};
        dv_z[0]   <= sq_z[SQ_STEPS];
        dv_neg[0] <= sq_neg[SQ_STEPS];
    end

    for (genvar j = 0; j < DV_STEPS; j++)
    begin : g_dv
        localparam int SH = Q_W - 1 - j;
        logic [NUM_W-1:0] sub;

        assign sub = NUM_W'(dv_d[j]) << SH;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v[j+1] <= 1'b0;
            end
            else
            begin
                dv_v[j+1] <= dv_v[j];
            end
        end

        for (genvar c = 0; c < 3; c++)
        begin : g_comp
            logic take;
            assign take = (dv_rem[j][c] >= sub);

            always_ff @(posedge clk)
            begin
                dv_rem[j+1][c] <= take ? dv_rem[j][c] - sub : dv_rem[j][c];
                dv_q[j+1][c]   <= {dv_q[j][c][Q_W-2:0], take};
            end
        end

        always_ff @(posedge clk)
        begin
            dv_d[j+1]   <= dv_d[j];
            dv_z[j+1]   <= dv_z[j];
            dv_neg[j+1] <= dv_neg[j];
        end
    end

    // clamp and apply sign
    always_comb
    begin
        logic [Q_W-1:0] sat;
        for (int c = 0; c < 3; c++)
        begin
            sat = (dv_q[DV_STEPS][c] > Q_W'(tfn_pkg::UNIT_ONE))
                ? Q_W'(tfn_pkg::UNIT_ONE) : dv_q[DV_STEPS][c];
            unit_vec[c] = dv_neg[DV_STEPS][c] ? NORM_W'(-{1'b0, sat}) : NORM_W'({1'b0, sat});
        end
    end

    assign stat.valid = dv_v[DV_STEPS];
    assign stat.zero  = dv_z[DV_STEPS];

endmodule

>>> tb/tb_triangle_face_normal_top.sv
// Testbench for the triangle face normal block: random vertex writes and triangles, checked against a predictor.
module tb_triangle_face_normal_top;

    localparam int LATENCY      = 47;
    localparam int COORD_W      = tfn_pkg::COORD_W;
    localparam int ADDR_W       = tfn_pkg::ADDR_W;
    localparam int VERTEX_DEPTH = tfn_pkg::VERTEX_DEPTH;
    localparam int NORM_W       = tfn_pkg::NORM_W;
    localparam int UNIT_ONE     = tfn_pkg::UNIT_ONE;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    tfn_pkg::cmd_t    cmd;
    logic             done;
    tfn_pkg::result_t result;

    triangle_face_normal_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    // Commands waiting to be driven, and normals waiting to come out.
    tfn_pkg::cmd_t    pending_cmds[$];
    tfn_pkg::result_t normal_fifo[$];

    // Shadow of the vertex store and a record of which slots hold data.
    logic signed [COORD_W-1:0] shadow_x[VERTEX_DEPTH];
    logic signed [COORD_W-1:0] shadow_y[VERTEX_DEPTH];
    logic signed [COORD_W-1:0] shadow_z[VERTEX_DEPTH];
    bit                        slot_written[VERTEX_DEPTH];
    int                        written_slots[$];

    int  mismatch_count;
    bit  stim_done;
    bit  quiet_tail;
    int  gap_left;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Integer square root, floor.
    function automatic longint unsigned root_floor(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Scale the edge p - q to unit length in Q1.14; return 0 for a zero-length edge.
    function automatic bit unit_vector(input longint p[3], input longint q[3],
                                       output longint u[3]);
        longint unsigned m[3];
        bit              neg[3];
        longint unsigned len2;
        longint unsigned s;
        longint unsigned qt;
        longint          d;
        len2 = 0;
        for (int i = 0; i < 3; i++)
        begin
            d = p[i] - q[i];
            neg[i] = d < 0;
            m[i] = neg[i] ? -d : d;
            len2 += m[i] * m[i];
        end
        if (len2 == 0)
            return 0;
        s = root_floor(len2);
        for (int i = 0; i < 3; i++)
        begin
            qt = (m[i] * (UNIT_ONE * 2) + s) / (2 * s);
            if (qt > UNIT_ONE)
                qt = UNIT_ONE;
            u[i] = neg[i] ? -longint'(qt) : longint'(qt);
        end
        return 1;
    endfunction

    // One cross component, rounded half away from zero to Q1.14 and clamped.
    function automatic logic signed [NORM_W-1:0] cross_part(input longint a, b, c, d);
        longint          v;
        longint unsigned m;
        v = a * b - c * d;
        m = v < 0 ? -v : v;
        m = (m + (64'd1 << 13)) >> 14;
        if (m > UNIT_ONE)
            m = UNIT_ONE;
        return v < 0 ? NORM_W'(-longint'(m)) : NORM_W'(m);
    endfunction

    // Predict the block's answer to one transfer; update the shadow store on writes.
    function automatic void predict_normal(input tfn_pkg::cmd_t c);
        longint           pa[3], pb[3], pc[3];
        longint           u0[3], u1[3];
        tfn_pkg::result_t r;
        if (c.op == tfn_pkg::OP_WRITE)
        begin
            shadow_x[c.vertex_slot] = c.coord_x;
            shadow_y[c.vertex_slot] = c.coord_y;
            shadow_z[c.vertex_slot] = c.coord_z;
            return;
        end
        pa = '{shadow_x[c.index_a], shadow_y[c.index_a], shadow_z[c.index_a]};
        pb = '{shadow_x[c.index_b], shadow_y[c.index_b], shadow_z[c.index_b]};
        pc = '{shadow_x[c.index_c], shadow_y[c.index_c], shadow_z[c.index_c]};
        r = '0;
        if (unit_vector(pa, pb, u0) && unit_vector(pb, pc, u1))
        begin
            r.normal_x = cross_part(u0[1], u1[2], u0[2], u1[1]);
            r.normal_y = cross_part(u0[2], u1[0], u0[0], u1[2]);
            r.normal_z = cross_part(u0[0], u1[1], u0[1], u1[0]);
        end
        else
            r.degenerate = 1'b1;
        normal_fifo.push_back(r);
    endfunction

    // Queue a vertex write and remember the slot as readable.
    task automatic add_vertex(input int slot, input int x, input int y, input int z);
        tfn_pkg::cmd_t c;
        c = '0;
        c.op          = tfn_pkg::OP_WRITE;
        c.vertex_slot = ADDR_W'(slot);
        c.coord_x     = COORD_W'(x);
        c.coord_y     = COORD_W'(y);
        c.coord_z     = COORD_W'(z);
        c.index_a     = ADDR_W'($urandom);
        c.index_b     = ADDR_W'($urandom);
        c.index_c     = ADDR_W'($urandom);
        pending_cmds.push_back(c);
        if (!slot_written[slot])
        begin
            slot_written[slot] = 1;
            written_slots.push_back(slot);
        end
    endtask

    task automatic add_triangle(input int a, input int b, input int cc);
        tfn_pkg::cmd_t c;
        c = '0;
        c.op          = tfn_pkg::OP_TRI;
        c.coord_x     = COORD_W'($urandom);
        c.coord_y     = COORD_W'($urandom);
        c.coord_z     = COORD_W'($urandom);
        c.vertex_slot = ADDR_W'($urandom);
        c.index_a     = ADDR_W'(a);
        c.index_b     = ADDR_W'(b);
        c.index_c     = ADDR_W'(cc);
        pending_cmds.push_back(c);
    endtask

    function automatic int any_slot();
        return written_slots[$urandom_range(written_slots.size() - 1)];
    endfunction

    // Coordinate spread: full range, small local meshes, or extremes.
    function automatic int rand_coord(input int base);
        case ($urandom_range(3))
            0: return $signed(24'($urandom));
            1: return base + $signed(12'($urandom));
            2: return $urandom_range(1) ? 8388607 : -8388608;
            default: return base + int'($urandom_range(4)) - 2;
        endcase
    endfunction

    // Fill the command queue: directed corners first, then random meshes, stray triangles and lone writes.
    initial
    begin
        int base;
        int s0, s1, s2;
        // Extremes of the coordinate range and right triangles with legs of 256.
        add_vertex(0, 0, 0, 0);
        add_vertex(1023, 8388607, 8388607, 8388607);
        add_vertex(512, -8388608, -8388608, -8388608);
        add_vertex(1, 256, 0, 0);
        add_vertex(2, 0, 256, 0);
        add_vertex(3, 0, 0, 256);
        add_vertex(4, -8388608, 8388607, 0);
        add_vertex(5, 1, 0, 0);
        add_triangle(0, 1, 512);
        add_triangle(1023, 512, 4);
        add_triangle(1, 0, 2);
        add_triangle(0, 2, 3);
        add_triangle(3, 2, 1);
        add_triangle(0, 5, 1);
        // Zero-length edges: A equals B, B equals C, all the same.
        add_triangle(1, 1, 2);
        add_triangle(1, 2, 2);
        add_triangle(0, 0, 0);
        // Collinear corners give a zero normal without being degenerate.
        add_vertex(6, 512, 0, 0);
        add_triangle(0, 1, 6);
        // Rewrite a slot and use it at once.
        add_vertex(5, -1, -1, -1);
        add_triangle(5, 0, 1023);

        while (pending_cmds.size() < 1320)
        begin
            base = $signed(24'($urandom));
            s0 = $urandom_range(1023);
            s1 = $urandom_range(1023);
            s2 = $urandom_range(1023);
            if ($urandom_range(9) < 7)
            begin
                // Well-formed mesh: three fresh vertices then a triangle or two over them.
                add_vertex(s0, rand_coord(base), rand_coord(base), rand_coord(base));
                add_vertex(s1, rand_coord(base), rand_coord(base), rand_coord(base));
                add_vertex(s2, rand_coord(base), rand_coord(base), rand_coord(base));
                add_triangle(s0, s1, s2);
                if ($urandom_range(1))
                    add_triangle(s2, s0, s1);
            end
            else if ($urandom_range(1))
                add_triangle(any_slot(), any_slot(), any_slot());
            else
                add_vertex(s0, $signed(24'($urandom)), $signed(24'($urandom)),
                           $signed(24'($urandom)));
        end
    end

    // Driver: present the next command, with random bursts of idle cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            cmd       <= '0;
            gap_left  <= 0;
            stim_done <= 1'b0;
        end
        else
        begin
            // A transfer on this edge retires the presented command.
            if (start && !busy)
                predict_normal(cmd);
            quiet_tail = pending_cmds.size() < 200;
            if (start && busy)
            begin
                // hold the command until the block takes it
            end
            else if (gap_left > 0)
            begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_cmds.size() == 0)
            begin
                start     <= 1'b0;
                stim_done <= 1'b1;
            end
            else if (!quiet_tail && $urandom_range(7) == 0)
            begin
                start    <= 1'b0;
                gap_left <= $urandom_range(15);
            end
            else
            begin
                start <= 1'b1;
                cmd   <= pending_cmds.pop_front();
            end
        end
    end

    // Monitor: compare each strobed normal with the oldest prediction.
    always @(posedge clk)
    begin
        tfn_pkg::result_t want;
        if (rst_n && done)
        begin
            if (normal_fifo.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %p", result);
            end
            else
            begin
                want = normal_fifo.pop_front();
                if (result !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("normal mismatch: expected %p, got %p", want, result);
                end
            end
        end
    end

    initial
    begin
        mismatch_count = 0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done);
        // drain the pipeline, then allow a margin
        while (normal_fifo.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatch_count == 0 && normal_fifo.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
